>>> rtl/line_pixel_generator_unit_defines.svh
// ----------------------------------------------------------------------------
// Line pixel generator assertion macros
// Shared property shorthands, sampled on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef LINE_PIXEL_GENERATOR_UNIT_DEFINES_SVH
`define LINE_PIXEL_GENERATOR_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPG_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LPG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/lpg_pkg.sv
// ----------------------------------------------------------------------------
// Line pixel generator package
// Shared constants, operation codes and types of the line pixel generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpg_pkg;

   // Default coordinate width in bits.
   localparam int LPG_COORD_BITS = 12;

   // Item operation codes.
   localparam logic LPG_OP_LOAD = 1'b0;
   localparam logic LPG_OP_STEP = 1'b1;

   // Control of the item held in the input register.
   typedef struct packed {
      logic valid;
      logic op;
   } lpg_item_ctrl_type;

endpackage

>>> rtl/lpg_if.sv
// ----------------------------------------------------------------------------
// Line pixel generator channels
// Request and response valid/ready channels with their payload fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lpg_req_if
   import lpg_pkg::*;
#(
   parameter int COORD_BITS = LPG_COORD_BITS
);
   logic                         valid;
   logic                         ready;
   logic                         op;
   logic signed [COORD_BITS-1:0] start_x;
   logic signed [COORD_BITS-1:0] start_y;
   logic signed [COORD_BITS-1:0] end_x;
   logic signed [COORD_BITS-1:0] end_y;

   modport source (output valid, op, start_x, start_y, end_x, end_y, input ready);
   modport sink   (input valid, op, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lpg_rsp_if
   import lpg_pkg::*;
#(
   parameter int COORD_BITS = LPG_COORD_BITS
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] pixel_x;
   logic signed [COORD_BITS-1:0] pixel_y;
   logic                         last;

   modport source (output valid, pixel_x, pixel_y, last, input ready);
   modport sink   (input valid, pixel_x, pixel_y, last, output ready);
endinterface

>>> rtl/lpg_in_reg.sv
// ----------------------------------------------------------------------------
// Line pixel generator input register
// Captures one request item and holds it until the core consumes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpg_in_reg
   import lpg_pkg::*;
#(
   parameter int COORD_BITS = LPG_COORD_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   lpg_req_if.sink                      req,
   input  logic                         advance,
   output lpg_item_ctrl_type            item_ctrl,
   output logic signed [COORD_BITS-1:0] item_start_x,
   output logic signed [COORD_BITS-1:0] item_start_y,
   output logic signed [COORD_BITS-1:0] item_end_x,
   output logic signed [COORD_BITS-1:0] item_end_y
);

   logic                         valid_ff, valid_in;
   logic                         op_ff;
   logic signed [COORD_BITS-1:0] start_x_ff, start_y_ff, end_x_ff, end_y_ff;
   logic                         take;

   // The register frees up in the same cycle its item moves on.
   assign req.ready = !valid_ff || advance;
   assign take      = req.valid && req.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         op_ff      <= req.op;
         start_x_ff <= req.start_x;
         start_y_ff <= req.start_y;
         end_x_ff   <= req.end_x;
         end_y_ff   <= req.end_y;
      end
   end

   assign item_ctrl.valid = valid_ff;
   assign item_ctrl.op    = op_ff;
   assign item_start_x    = start_x_ff;
   assign item_start_y    = start_y_ff;
   assign item_end_x      = end_x_ff;
   assign item_end_y      = end_y_ff;

endmodule

>>> rtl/lpg_setup.sv
// ----------------------------------------------------------------------------
// Line pixel generator setup
// Derives the octant, ordered endpoints and error terms of a new line.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpg_setup
   import lpg_pkg::*;
#(
   parameter int COORD_BITS = LPG_COORD_BITS
) (
   input  logic signed [COORD_BITS-1:0] start_x,
   input  logic signed [COORD_BITS-1:0] start_y,
   input  logic signed [COORD_BITS-1:0] end_x,
   input  logic signed [COORD_BITS-1:0] end_y,
   output logic                         steep,
   output logic signed [COORD_BITS-1:0] major_start,
   output logic signed [COORD_BITS-1:0] minor_start,
   output logic signed [COORD_BITS-1:0] major_end,
   output logic        [COORD_BITS:0]   error_inc,
   output logic        [COORD_BITS:0]   twice_major_span,
   output logic                         minor_dir_neg
);

   logic signed [COORD_BITS:0]   diff_x, diff_y;
   logic        [COORD_BITS-1:0] span_x, span_y, major_span, minor_span;
   logic signed [COORD_BITS-1:0] p0, p1, q0, q1, minor_end;
   logic                         swap;

   always_comb begin
      // Spans fit in COORD_BITS unsigned bits; the sign bit is dropped.
      diff_x = {start_x[COORD_BITS-1], start_x} - {end_x[COORD_BITS-1], end_x};
      diff_y = {start_y[COORD_BITS-1], start_y} - {end_y[COORD_BITS-1], end_y};
      span_x = diff_x[COORD_BITS] ? COORD_BITS'(-diff_x) : diff_x[COORD_BITS-1:0];
      span_y = diff_y[COORD_BITS] ? COORD_BITS'(-diff_y) : diff_y[COORD_BITS-1:0];

      // Equal spans keep x as the major axis.
      steep      = span_x < span_y;
      p0         = steep ? start_y : start_x;
      q0         = steep ? start_x : start_y;
      p1         = steep ? end_y   : end_x;
      q1         = steep ? end_x   : end_y;
      major_span = steep ? span_y  : span_x;
      minor_span = steep ? span_x  : span_y;

      swap          = p0 > p1;
      major_start   = swap ? p1 : p0;
      minor_start   = swap ? q1 : q0;
      major_end     = swap ? p0 : p1;
      minor_end     = swap ? q0 : q1;
      minor_dir_neg = !(minor_end > minor_start);

      error_inc        = {minor_span, 1'b0};
      twice_major_span = {major_span, 1'b0};
   end

endmodule

>>> rtl/lpg_core.sv
// ----------------------------------------------------------------------------
// Line pixel generator core
// Holds the line state, loads or steps it per item and registers the pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "line_pixel_generator_unit_defines.svh"

module lpg_core
   import lpg_pkg::*;
#(
   parameter int COORD_BITS = LPG_COORD_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  lpg_item_ctrl_type            item_ctrl,
   input  logic signed [COORD_BITS-1:0] item_start_x,
   input  logic signed [COORD_BITS-1:0] item_start_y,
   input  logic signed [COORD_BITS-1:0] item_end_x,
   input  logic signed [COORD_BITS-1:0] item_end_y,
   output logic                         advance,
   lpg_rsp_if.source                    rsp
);

   // The error term stays within three major spans, plus a sign bit.
   localparam int ErrBits = COORD_BITS + 3;

   logic                         active_ff, active_in;
   logic                         steep_ff, steep_in;
   logic signed [COORD_BITS-1:0] major_pos_ff, major_pos_in;
   logic signed [COORD_BITS-1:0] minor_pos_ff, minor_pos_in;
   logic signed [COORD_BITS-1:0] major_end_ff, major_end_in;
   logic signed [ErrBits-1:0]    error_acc_ff, error_acc_in;
   logic        [COORD_BITS:0]   error_inc_ff, error_inc_in;
   logic        [COORD_BITS:0]   twice_major_span_ff, twice_major_span_in;
   logic                         minor_dir_neg_ff, minor_dir_neg_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_BITS-1:0] pixel_x_ff, pixel_y_ff;
   logic                         last_ff;

   logic                         set_steep, set_dir_neg;
   logic signed [COORD_BITS-1:0] set_major_start, set_minor_start, set_major_end;
   logic        [COORD_BITS:0]   set_error_inc, set_twice_span;

   logic                         out_free, is_step, emit, at_end, minor_move;
   logic signed [ErrBits-1:0]    acc_sum, half_span;

   lpg_setup #(
      .COORD_BITS (COORD_BITS)
   ) u_setup (
      .start_x          (item_start_x),
      .start_y          (item_start_y),
      .end_x            (item_end_x),
      .end_y            (item_end_y),
      .steep            (set_steep),
      .major_start      (set_major_start),
      .minor_start      (set_minor_start),
      .major_end        (set_major_end),
      .error_inc        (set_error_inc),
      .twice_major_span (set_twice_span),
      .minor_dir_neg    (set_dir_neg)
   );

   always_comb begin
      out_free   = !rsp_valid_ff || rsp.ready;
      advance    = item_ctrl.valid && out_free;
      is_step    = item_ctrl.op == LPG_OP_STEP;
      emit       = advance && is_step && active_ff;
      at_end     = major_pos_ff == major_end_ff;
      acc_sum    = error_acc_ff + $signed({2'b00, error_inc_ff});
      half_span  = $signed({3'b000, twice_major_span_ff[COORD_BITS:1]});
      minor_move = acc_sum > half_span;

      active_in           = active_ff;
      steep_in            = steep_ff;
      major_pos_in        = major_pos_ff;
      minor_pos_in        = minor_pos_ff;
      major_end_in        = major_end_ff;
      error_acc_in        = error_acc_ff;
      error_inc_in        = error_inc_ff;
      twice_major_span_in = twice_major_span_ff;
      minor_dir_neg_in    = minor_dir_neg_ff;

      if (advance && !is_step) begin
         active_in           = 1'b1;
         steep_in            = set_steep;
         major_pos_in        = set_major_start;
         minor_pos_in        = set_minor_start;
         major_end_in        = set_major_end;
         error_acc_in        = '0;
         error_inc_in        = set_error_inc;
         twice_major_span_in = set_twice_span;
         minor_dir_neg_in    = set_dir_neg;
      end else if (emit) begin
         if (at_end) begin
            active_in = 1'b0;
         end else begin
            major_pos_in = major_pos_ff + COORD_BITS'(1);
            if (minor_move) begin
               minor_pos_in = minor_dir_neg_ff ? minor_pos_ff - COORD_BITS'(1)
                                               : minor_pos_ff + COORD_BITS'(1);
               error_acc_in = acc_sum - $signed({2'b00, twice_major_span_ff});
            end else begin
               error_acc_in = acc_sum;
            end
         end
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      steep_ff            <= steep_in;
      major_pos_ff        <= major_pos_in;
      minor_pos_ff        <= minor_pos_in;
      major_end_ff        <= major_end_in;
      error_acc_ff        <= error_acc_in;
      error_inc_ff        <= error_inc_in;
      twice_major_span_ff <= twice_major_span_in;
      minor_dir_neg_ff    <= minor_dir_neg_in;
      if (emit) begin
         pixel_x_ff <= steep_ff ? minor_pos_ff : major_pos_ff;
         pixel_y_ff <= steep_ff ? major_pos_ff : minor_pos_ff;
         last_ff    <= at_end;
      end
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.pixel_x = pixel_x_ff;
   assign rsp.pixel_y = pixel_y_ff;
   assign rsp.last    = last_ff;

   `LPG_ASSERT_NEXT(a_load_activates, advance && !is_step, active_ff, "load did not start a line")
   `LPG_ASSERT_NEXT(a_last_ends_line, emit && at_end, !active_ff, "line open after last pixel")
   `LPG_ASSERT_NEXT(a_emit_shows, emit, rsp_valid_ff, "stepped pixel was not presented")
   `LPG_ASSERT_SAME(a_major_in_range, active_ff, major_pos_ff <= major_end_ff, "major past end")
   `LPG_ASSERT_SAME(a_error_bound, active_ff, error_acc_ff <= half_span, "error above half span")

endmodule

>>> rtl/line_pixel_generator_unit.sv
// ----------------------------------------------------------------------------
// Line pixel generator unit: a request passes the input register, then the
// pixel register. One item is taken every cycle while no pixel is held back;
// throughput is set by the single pass through the state update logic.
// Synchronous active-high reset idles the line and empties both registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_pixel_generator_unit
   import lpg_pkg::*;
#(
   parameter int COORD_BITS = LPG_COORD_BITS
) (
   input  logic      clock,
   input  logic      reset,
   lpg_req_if.sink   req,
   lpg_rsp_if.source rsp
);

   // The unit rasterizes lines with the integer Bresenham method. A request
   // transfer carries either a load, which sets up a new line from two
   // endpoints and replaces any line still in progress, or a step, which
   // produces the next pixel of the active line. A step with no active line
   // produces nothing.

   // Control of the item waiting in the input register.
   lpg_item_ctrl_type            item_ctrl;
   logic signed [COORD_BITS-1:0] item_start_x;
   logic signed [COORD_BITS-1:0] item_start_y;
   logic signed [COORD_BITS-1:0] item_end_x;
   logic signed [COORD_BITS-1:0] item_end_y;

   // High when the core consumes the held item in this cycle.
   logic                         advance;

   // The input register takes a new transfer in the same cycle the held item
   // moves into the core, so requests stream at one per clock unless stalled.
   lpg_in_reg #(
      .COORD_BITS (COORD_BITS)
   ) u_in_reg (
      .clock        (clock),
      .reset        (reset),
      .req          (req),
      .advance      (advance),
      .item_ctrl    (item_ctrl),
      .item_start_x (item_start_x),
      .item_start_y (item_start_y),
      .item_end_x   (item_end_x),
      .item_end_y   (item_end_y)
   );

   // The core reads and updates the line state in one pass and registers the
   // pixel. It consumes an item whenever the response register is empty or
   // is being emptied, so a pixel that leaves in the same cycle does not stop
   // a new transfer. A pixel that is still waiting holds the item in place.
   lpg_core #(
      .COORD_BITS (COORD_BITS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .item_ctrl    (item_ctrl),
      .item_start_x (item_start_x),
      .item_start_y (item_start_y),
      .item_end_x   (item_end_x),
      .item_end_y   (item_end_y),
      .advance      (advance),
      .rsp          (rsp)
   );

endmodule

>>> verif/tb_line_pixel_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line pixel generator unit testbench
// Sends load and step transfers to the line rasterizer and rebuilds every
// pixel in an independent Bresenham tracer. Each response transfer is checked
// against the oldest pixel that the tracer predicted. Both channels idle at
// random, except during one steady stretch and one long response hold-off.
// ----------------------------------------------------------------------------

module tb_line_pixel_generator_unit;
   import lpg_pkg::*;

   localparam int CB        = LPG_COORD_BITS;
   localparam int COORD_MIN = -(1 << (CB - 1));
   localparam int COORD_MAX = (1 << (CB - 1)) - 1;

   typedef logic signed [CB-1:0] coord_type;

   // One request: a load of two endpoints or a step to the next pixel.
   typedef struct {
      logic      op;
      coord_type start_x;
      coord_type start_y;
      coord_type end_x;
      coord_type end_y;
   } line_cmd_type;

   // One plotted pixel as the response channel carries it.
   typedef struct {
      coord_type x;
      coord_type y;
      logic      last;
   } line_pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lpg_req_if #(.COORD_BITS(CB)) req_ch ();
   lpg_rsp_if #(.COORD_BITS(CB)) rsp_ch ();

   line_pixel_generator_unit #(
      .COORD_BITS(CB)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch)
   );

   // The tracer keeps its own copy of the line state. After reset no line is
   // active and all terms are zero. The coordinates are held in the swapped
   // frame: the major axis is the one with the larger span.
   logic               trace_active     = 1'b0;
   logic               trace_steep      = 1'b0;
   logic               trace_minor_down = 1'b0;
   coord_type          trace_major      = '0;
   coord_type          trace_minor      = '0;
   coord_type          trace_major_end  = '0;
   logic signed [15:0] trace_error      = '0;
   logic signed [13:0] trace_error_inc  = '0;
   logic signed [13:0] trace_twice_span = '0;

   // Pixels that the tracer produced and the block has not yet delivered.
   line_pixel_type pending_pixels[$];

   int mismatch_count = 0;
   int sent_count     = 0;

   // While set, neither side inserts random idle cycles.
   bit steady_flow   = 1'b0;
   // Cycles for which the response side must hold ready low. The receiver
   // process counts this down on its own.
   int holdoff_cycles = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int coord_span(input int a, input int b);
      return (a > b) ? a - b : b - a;
   endfunction

   // Applies one request to the tracer. A step on an active line returns 1
   // and the pixel it plots; a load and a step with no line return 0.
   function automatic bit trace_line(input line_cmd_type cmd, output line_pixel_type pix);
      int ax, ay, bx, by, swap;
      pix = '{x: '0, y: '0, last: 1'b0};
      if (cmd.op == LPG_OP_LOAD) begin
         ax = int'(cmd.start_x);
         ay = int'(cmd.start_y);
         bx = int'(cmd.end_x);
         by = int'(cmd.end_y);
         // Equal spans keep x as the major axis.
         trace_steep = coord_span(ax, bx) < coord_span(ay, by);
         if (trace_steep) begin
            swap = ax; ax = ay; ay = swap;
            swap = bx; bx = by; by = swap;
         end
         // Walk the major axis upward, so take the lower endpoint first.
         if (ax > bx) begin
            swap = ax; ax = bx; bx = swap;
            swap = ay; ay = by; by = swap;
         end
         trace_major      = coord_type'(ax);
         trace_minor      = coord_type'(ay);
         trace_major_end  = coord_type'(bx);
         trace_error      = '0;
         trace_error_inc  = 14'(2 * coord_span(ay, by));
         trace_twice_span = 14'(2 * (bx - ax));
         trace_minor_down = !(by > ay);
         trace_active     = 1'b1;
         return 1'b0;
      end
      if (!trace_active) begin
         return 1'b0;
      end
      pix.x    = trace_steep ? trace_minor : trace_major;
      pix.y    = trace_steep ? trace_major : trace_minor;
      pix.last = (trace_major == trace_major_end);
      if (pix.last) begin
         trace_active = 1'b0;
      end else begin
         trace_major = coord_type'(trace_major + 1);
         trace_error = trace_error + trace_error_inc;
         // The minor coordinate moves once the error passes half a pixel.
         if (trace_error > trace_twice_span / 2) begin
            trace_minor = coord_type'(trace_minor + (trace_minor_down ? -1 : 1));
            trace_error = trace_error - trace_twice_span;
         end
      end
      return 1'b1;
   endfunction

   function automatic line_cmd_type load_cmd(input int sx, input int sy, input int ex,
                                             input int ey);
      load_cmd = '{op: LPG_OP_LOAD, start_x: coord_type'(sx), start_y: coord_type'(sy),
                   end_x: coord_type'(ex), end_y: coord_type'(ey)};
   endfunction

   // A step carries endpoint fields that the block must ignore, so they are
   // filled with noise.
   function automatic line_cmd_type step_cmd();
      step_cmd = '{op: LPG_OP_STEP, start_x: coord_type'($urandom),
                   start_y: coord_type'($urandom), end_x: coord_type'($urandom),
                   end_y: coord_type'($urandom)};
   endfunction

   // Picks a coordinate within reach of a base point, kept inside the range.
   function automatic int near_coord(input int base, input int reach);
      int lo, hi;
      lo = (base - reach < COORD_MIN) ? COORD_MIN : base - reach;
      hi = (base + reach > COORD_MAX) ? COORD_MAX : base + reach;
      return lo + int'($urandom_range(hi - lo));
   endfunction

   // Offers one request and returns at the falling edge after its transfer.
   // The caller is always at a falling edge, where the inputs change. The
   // tracer is advanced at the rising edge of the transfer itself.
   task automatic send_cmd(input line_cmd_type cmd);
      line_pixel_type pix;
      if (!steady_flow && $urandom_range(99) < 36) begin
         req_ch.valid <= 1'b0;
         do begin
            @(negedge clock);
         end while ($urandom_range(99) < 36);
      end
      req_ch.valid   <= 1'b1;
      req_ch.op      <= cmd.op;
      req_ch.start_x <= cmd.start_x;
      req_ch.start_y <= cmd.start_y;
      req_ch.end_x   <= cmd.end_x;
      req_ch.end_y   <= cmd.end_y;
      do begin
         @(posedge clock);
      end while (!req_ch.ready);
      if (trace_line(cmd, pix)) begin
         pending_pixels.push_back(pix);
      end
      sent_count++;
      @(negedge clock);
   endtask

   // Steps with no line loaded since reset must produce nothing.
   task automatic test_idle_steps();
      send_cmd('{op: LPG_OP_STEP, start_x: '0, start_y: '0, end_x: '0, end_y: '0});
      send_cmd('{op: LPG_OP_STEP, start_x: '1, start_y: '1, end_x: '1, end_y: '1});
   endtask

   task automatic test_directed_lines();
      // Corner to corner with equal spans: x stays major and y walks down.
      send_cmd(load_cmd(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN));
      repeat (2) send_cmd(step_cmd());
      // The other diagonal, given right to left; it replaces the open line.
      send_cmd(load_cmd(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX));
      send_cmd(step_cmd());
      // A single point plots once with last set, then the line is closed and
      // a step with extreme endpoint fields produces nothing.
      send_cmd(load_cmd(7, -7, 7, -7));
      send_cmd(step_cmd());
      send_cmd('{op: LPG_OP_STEP, start_x: coord_type'(COORD_MAX),
                 start_y: coord_type'(COORD_MIN), end_x: coord_type'(COORD_MIN),
                 end_y: coord_type'(COORD_MAX)});
      // Vertical line given top down: steep, endpoints reordered.
      send_cmd(load_cmd(3, 1, 3, -1));
      repeat (3) send_cmd(step_cmd());
      // Horizontal line given right to left: the error never trips.
      send_cmd(load_cmd(2, -5, -1, -5));
      repeat (4) send_cmd(step_cmd());
      // Steep line given from its upper end; the minor coordinate rises with the major one.
      send_cmd(load_cmd(1, 3, 0, 0));
      repeat (4) send_cmd(step_cmd());
   endtask

   // Mostly whole lines with random endpoints, each followed by its steps.
   // Some lines are cut short by the next load or run past their end, and a
   // small share of transfers are lone loads or steps. Most lines are short;
   // a few may reach across the whole range, and no line gets over 40 steps.
   task automatic test_random_lines(input int item_goal);
      int kind, reach, len, steps, sx, sy;
      while (sent_count < item_goal) begin
         kind = $urandom_range(99);
         if (kind < 8) begin
            send_cmd($urandom_range(1) ? step_cmd() : load_cmd($urandom, $urandom,
                                                              $urandom, $urandom));
         end else begin
            reach = (kind < 11) ? COORD_MAX - COORD_MIN : (kind < 40) ? 3 : 24;
            sx = COORD_MIN + int'($urandom_range(COORD_MAX - COORD_MIN));
            sy = COORD_MIN + int'($urandom_range(COORD_MAX - COORD_MIN));
            send_cmd(load_cmd(sx, sy, near_coord(sx, reach), near_coord(sy, reach)));
            len = int'(trace_major_end) - int'(trace_major) + 1;
            if ($urandom_range(4) == 0) begin
               steps = $urandom_range(len);
            end else begin
               steps = len + $urandom_range(2);
            end
            if (steps > 40) begin
               steps = 40;
            end
            repeat (steps) send_cmd(step_cmd());
         end
      end
   endtask

   // A long stretch in which both sides transfer on every cycle they can.
   task automatic test_steady_stream(input int item_goal);
      steady_flow = 1'b1;
      test_random_lines(item_goal);
      steady_flow = 1'b0;
   endtask

   // The response side holds off for a long time while steps keep coming,
   // so the block fills up and must stall the request side.
   task automatic test_output_stall();
      steady_flow = 1'b1;
      send_cmd(load_cmd(-300, 20, 300, -77));
      holdoff_cycles = 200;
      repeat (160) send_cmd(step_cmd());
      steady_flow = 1'b0;
   endtask

   // Response ready: random idling, none in the steady stretch, and a long
   // hold-off when one is requested.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holdoff_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            holdoff_cycles--;
         end else if (!steady_flow && $urandom_range(99) < 36) begin
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic compare_field(input string field, input logic signed [31:0] want,
                                input logic signed [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   // Every response transfer is matched against the oldest predicted pixel.
   always @(posedge clock) begin : pixel_check
      line_pixel_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected pixel, expected none, actual (%0d, %0d) last %b",
                     $time, rsp_ch.pixel_x, rsp_ch.pixel_y, rsp_ch.last);
            mismatch_count++;
         end else begin
            want = pending_pixels.pop_front();
            compare_field("pixel_x", 32'(want.x), 32'(rsp_ch.pixel_x));
            compare_field("pixel_y", 32'(want.y), 32'(rsp_ch.pixel_y));
            compare_field("last", {31'd0, want.last}, {31'd0, rsp_ch.last});
         end
      end
   end

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.op      = LPG_OP_LOAD;
      req_ch.start_x = '0;
      req_ch.start_y = '0;
      req_ch.end_x   = '0;
      req_ch.end_y   = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_idle_steps();
      test_directed_lines();
      test_random_lines(450);
      test_steady_stream(650);
      test_output_stall();
      test_random_lines(1050);
      req_ch.valid <= 1'b0;

      // Drain the pipeline, then keep watching for any stray pixel.
      while (pending_pixels.size() != 0) begin
         @(posedge clock);
      end
      repeat (6) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_line_pixel_generator_unit OK");
      end else begin
         $display("tb_line_pixel_generator_unit NOT OK");
      end
      $finish;
   end

   // This watchdog ends a hung run, far beyond the time the slowest correct run takes.
   initial begin
      #400000;
      $display("tb_line_pixel_generator_unit NOT OK");
      $finish;
   end

endmodule
